// ----- hdl/dq_pkg.sv -----
package dq_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 7;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill_count;
    } result_t;

    // Store access decided by the pointer unit for the item at hand.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [STAT_W-1:0] status;
    } access_t;

endpackage

// ----- hdl/dq_ram.sv -----
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/dq_ptr.sv -----
module dq_ptr #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  dq_pkg::item_t              item,
    output dq_pkg::access_t            access,
    output logic [$clog2(DEPTH)-1:0]   addr,
    output logic [$clog2(DEPTH+1)-1:0] count_after
);

    import dq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [AW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   front_inc, front_dec;
    logic [CW-1:0]   offset;
    logic [CW:0]     ring_sum;
    logic [CW:0]     ring_slot;
    logic            use_front_dec;
    logic            full, empty;
    logic [CMPW-1:0] pos_ext, cnt_ext;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMPW'(item.position);
    assign cnt_ext = CMPW'(count_reg);

    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);

    // front + offset stays below twice the depth, so one conditional subtract wraps it.
    assign ring_sum  = (CW+1)'(front_reg) + (CW+1)'(offset);
    assign ring_slot = (ring_sum >= (CW+1)'(DEPTH)) ? ring_sum - (CW+1)'(DEPTH) : ring_sum;
    assign addr      = use_front_dec ? front_dec : ring_slot[AW-1:0];

    always_comb
    begin
        access        = '0;
        access.status = ST_OK;
        offset        = '0;
        use_front_dec = 1'b0;
        front_next    = front_reg;
        count_next    = count_reg;
        case (item.operation)
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    access.status = ST_FULL;
                end
                else
                begin
                    access.wr_en = 1'b1;
                    offset       = count_reg;
                    count_next   = count_reg + CW'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    access.status = ST_FULL;
                end
                else
                begin
                    access.wr_en  = 1'b1;
                    use_front_dec = 1'b1;
                    front_next    = front_dec;
                    count_next    = count_reg + CW'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    access.status = ST_EMPTY;
                end
                else
                begin
                    access.rd_en = 1'b1;
                    offset       = count_reg - CW'(1);
                    count_next   = count_reg - CW'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    access.status = ST_EMPTY;
                end
                else
                begin
                    access.rd_en = 1'b1;
                    front_next   = front_inc;
                    count_next   = count_reg - CW'(1);
                end
            end
            OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    access.status = ST_RANGE;
                end
                else
                begin
                    access.rd_en = 1'b1;
                    offset       = pos_ext[CW-1:0];
                end
            end
            default:
            begin
                access.status = ST_OK;
            end
        endcase
    end

    assign count_after = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/double_ended_queue.sv -----
// Channel | Direction | Payload  | Transfer when
// item    | in        | item_t   | item_valid && item_ready
// result  | out       | result_t | result_valid && result_ready
//
// Pushes, unused codes and items that end in an error status are answered straight from the
// result register; pops and reads that succeed first pass the registered store read and S_READ.
// One item is in work at a time; the next is taken once the result register is free.
// A stalled result is held in the output register and blocks further items.
// Reset clears the front slot, the element count and the control state.
module double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  dq_pkg::item_t   item,
    output logic            result_valid,
    input  logic            result_ready,
    output dq_pkg::result_t result
);

    import dq_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXTW  = (CW > FILL_W) ? CW : FILL_W;
    localparam int DXW   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic            result_valid_reg, result_valid_next;
    result_t         result_reg, result_next;
    logic            accept;
    access_t         access;
    logic [AW-1:0]   addr;
    logic [CW-1:0]   count_after;
    logic [EXTW-1:0] fill_ext;
    logic [DXW-1:0]  wr_ext, rd_ext;
    logic [DATA_WIDTH-1:0] rd_data;

    assign item_ready = (state_reg == S_IDLE) && (!result_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;

    dq_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .access     (access),
        .addr       (addr),
        .count_after(count_after)
    );

    assign wr_ext = DXW'(item.value);

    dq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (accept && access.wr_en),
        .rd_en  (accept && access.rd_en),
        .addr   (addr),
        .wr_data(wr_ext[DATA_WIDTH-1:0]),
        .rd_data(rd_data)
    );

    assign rd_ext   = DXW'(rd_data);
    assign fill_ext = EXTW'(count_after);

    always_comb
    begin
        state_next        = state_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.data       = '0;
                    result_next.status     = access.status;
                    result_next.fill_count = fill_ext[FILL_W-1:0];
                    if (access.rd_en)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // The result register was freed when the item was taken.
                result_next.data  = rd_ext[DATA_W-1:0];
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- hdl/dq_checker.sv -----
module dq_checker #(
    parameter int DEPTH = 64
) (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_ready,
    input logic            result_valid,
    input logic            result_ready,
    input dq_pkg::result_t result
);

    import dq_pkg::*;

    // A held result stays put until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

    // Only one item is in work, so a stalled result blocks new items.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !item_ready)
    else $error("item taken while a result is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |-> result.data == '0)
    else $error("nonzero data with an error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (DEPTH > 127) || (int'(result.fill_count) <= DEPTH))
    else $error("fill count above capacity");

    // A taken item is answered in time; a stalled receiver cannot delay the answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |-> ##2 ($past(result_valid) || result_valid))
    else $error("item not answered in time");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH(DEPTH)
) u_dq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

// ----- tb/testbench.sv -----
module testbench;
    import dq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    // Operation codes the block leaves unused; they must pass through as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;

    // Shadow copy of the deque contents.
    logic [DATA_W-1:0] shadow_store [QUEUE_DEPTH];
    logic [POS_W-1:0] head_slot = '0;
    logic [FILL_W-1:0] shadow_count = '0;

    result_t pending_outcomes[$];
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    double_ended_queue #(
        .DEPTH(QUEUE_DEPTH),
        .DATA_WIDTH(DATA_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one operation to the shadow deque and returns the outcome it must produce.
    function automatic result_t deque_outcome(input item_t op_item);
        result_t outcome;
        logic [POS_W-1:0] slot;
        outcome = '0;
        outcome.status = ST_OK;
        case (op_item.operation)
            OP_PUSH_BACK:
            begin
                if (shadow_count == QUEUE_DEPTH)
                    outcome.status = ST_FULL;
                else
                begin
                    slot = head_slot + shadow_count[POS_W-1:0];
                    shadow_store[slot] = op_item.value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            OP_PUSH_FRONT:
            begin
                if (shadow_count == QUEUE_DEPTH)
                    outcome.status = ST_FULL;
                else
                begin
                    head_slot = head_slot - 1'b1;
                    shadow_store[head_slot] = op_item.value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (shadow_count == 0)
                    outcome.status = ST_EMPTY;
                else
                begin
                    // With a full deque the low bits of the count wrap to zero,
                    // and head minus one still lands on the last element.
                    slot = head_slot + shadow_count[POS_W-1:0] - 1'b1;
                    outcome.data = shadow_store[slot];
                    shadow_count = shadow_count - 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (shadow_count == 0)
                    outcome.status = ST_EMPTY;
                else
                begin
                    outcome.data = shadow_store[head_slot];
                    head_slot = head_slot + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            OP_READ:
            begin
                if (FILL_W'(op_item.position) >= shadow_count)
                    outcome.status = ST_RANGE;
                else
                begin
                    slot = head_slot + op_item.position;
                    outcome.data = shadow_store[slot];
                end
            end
            default:
            begin
            end
        endcase
        outcome.fill_count = shadow_count;
        return outcome;
    endfunction

    function automatic item_t make_op(input logic [OP_W-1:0] operation,
                                      input logic [VALUE_W-1:0] value,
                                      input logic [POS_W-1:0] position);
        item_t op_item;
        op_item.operation = operation;
        op_item.value = value;
        op_item.position = position;
        return op_item;
    endfunction

    // Random operation; filling leans toward pushes, otherwise toward pops.
    function automatic item_t pick_op(input bit filling);
        item_t op_item;
        int unsigned roll;
        roll = $urandom_range(99);
        op_item.value = $urandom;
        op_item.position = POS_W'($urandom);
        if (roll < 4)
            op_item.operation = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else if (roll < (filling ? 64 : 24))
            op_item.operation = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (roll < 84)
            op_item.operation = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        else
        begin
            op_item.operation = OP_READ;
            // Mostly aim inside the held range so reads return data.
            if (shadow_count != 0 && $urandom_range(3) != 0)
                op_item.position = POS_W'($urandom_range(shadow_count - 1));
        end
        return op_item;
    endfunction

    task automatic send_op(input item_t op_item);
        while ($urandom_range(99) < send_gap_pct)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= op_item;
        do
            @(posedge clk);
        while (!item_ready);
        pending_outcomes.insert(pending_outcomes.size(), deque_outcome(op_item));
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected result, data", result.data, '0);
            else
            begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                if (result.data !== want.data)
                    report_mismatch("data", result.data, want.data);
                if (result.status !== want.status)
                    report_mismatch("status", DATA_W'(result.status), DATA_W'(want.status));
                if (result.fill_count !== want.fill_count)
                    report_mismatch("fill_count", DATA_W'(result.fill_count),
                                    DATA_W'(want.fill_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Empty pops, out-of-range reads, unused codes, and pushes at both ends.
    task automatic test_corner_ops();
        send_op(make_op(OP_POP_BACK, 32'h1234_5678, '0));
        send_op(make_op(OP_POP_FRONT, 32'h0, '1));
        send_op(make_op(OP_READ, 32'h0, 6'd0));
        send_op(make_op(OP_READ, 32'hFFFF_FFFF, 6'd63));
        send_op(make_op(OP_PUSH_BACK, 32'h0000_0000, 6'd63));
        send_op(make_op(OP_PUSH_BACK, 32'hFFFF_FFFF, 6'd0));
        send_op(make_op(OP_PUSH_FRONT, 32'hA5A5_A5A5, 6'd21));
        send_op(make_op(OP_PUSH_FRONT, 32'h5A5A_5A5A, 6'd42));
        send_op(make_op(OP_READ, 32'h0, 6'd0));
        send_op(make_op(OP_READ, 32'h0, 6'd3));
        send_op(make_op(OP_READ, 32'h0, 6'd4));
        send_op(make_op(OP_READ, 32'h0, 6'd63));
        send_op(make_op(OP_SPARE_LO, 32'hDEAD_BEEF, 6'd1));
        send_op(make_op(OP_SPARE_MID, 32'hFFFF_FFFF, 6'd63));
        send_op(make_op(OP_SPARE_HI, 32'h0, 6'd0));
        send_op(make_op(OP_POP_FRONT, 32'h0, 6'd0));
        send_op(make_op(OP_POP_BACK, 32'h0, 6'd0));
        send_op(make_op(OP_POP_FRONT, 32'h0, 6'd0));
        send_op(make_op(OP_POP_BACK, 32'h0, 6'd0));
        send_op(make_op(OP_POP_BACK, 32'h0, 6'd0));
        send_op(make_op(OP_PUSH_FRONT, 32'h0000_0001, 6'd0));
        send_op(make_op(OP_POP_BACK, 32'h0, 6'd0));
        send_op(make_op(OP_PUSH_BACK, 32'h8000_0000, 6'd0));
        send_op(make_op(OP_POP_FRONT, 32'h0, 6'd0));
    endtask

    // Fills to capacity from both ends, pushes into a full deque, then drains it.
    task automatic test_full_deque();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_op(make_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, '0));
        send_op(make_op(OP_PUSH_BACK, $urandom, '0));
        send_op(make_op(OP_PUSH_FRONT, $urandom, '0));
        send_op(make_op(OP_READ, 32'h0, 6'd63));
        send_op(make_op(OP_READ, 32'h0, 6'd0));
        send_op(make_op(OP_READ, 32'h0, 6'd32));
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_op(make_op(i[0] ? OP_POP_BACK : OP_POP_FRONT, '0, '0));
        send_op(make_op(OP_POP_FRONT, 32'h0, 6'd0));
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_left = 80;
        for (int i = 0; i < 40; i++)
            send_op(pick_op(i < 30));
    endtask

    // Alternates fill and drain stretches so the deque level rises and falls.
    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int count);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_op(pick_op(((i / 48) % 2) == 0));
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_corner_ops();
        test_full_deque();
        test_backpressure();
        test_random_traffic(0, 0, 380);
        test_random_traffic(49, 0, 380);
        test_random_traffic(0, 49, 380);
        test_random_traffic(6, 6, 380);

        @(negedge clk);
        item_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_ptr.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
tb/testbench.sv
